>>> rtl/pair_run_length_encoder_macros.svh
// assertion macros for the pair run-length encoder
// used by modules that check their own logic; expects clk and rst_n in scope
`ifndef PAIR_RUN_LENGTH_ENCODER_MACROS_SVH
`define PAIR_RUN_LENGTH_ENCODER_MACROS_SVH

// same-cycle implication
`define PRLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/prle_pkg.sv
// shared types and constants of the pair run-length encoder
// no dependencies
`default_nettype none
package prle_pkg;
  localparam int MaxLitBytes = 252;
  localparam int MaxRunBytes = 126;
  localparam int LenW        = $clog2(MaxLitBytes + 1);
  localparam int MemDepth    = MaxLitBytes / 2;
  localparam int PairAw      = $clog2(MemDepth);
  localparam logic [7:0] RunFlag = 8'h80;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_LIT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       term;
  } byte_req_t;
endpackage
`default_nettype wire

>>> rtl/prle_if.sv
// valid/ready channel interfaces for pair input and packed output
// depends on nothing
`default_nettype none
interface prle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic       last_pair;
  modport source (output valid, first_byte, second_byte, last_pair, input ready);
  modport sink (input valid, first_byte, second_byte, last_pair, output ready);
endinterface

interface prle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_bytes;
  logic [3:0]  byte_count;
  logic        end_of_line;
  modport source (output valid, packed_bytes, byte_count, end_of_line, input ready);
  modport sink (input valid, packed_bytes, byte_count, end_of_line, output ready);
endinterface
`default_nettype wire

>>> rtl/pair_run_length_encoder.sv
// top level of the pair run-length encoder: sequencer plus output byte packer
// depends on prle_pkg, prle_if, prle_ctrl and prle_packer
//
// Takes one line as byte pairs and sends packbits-style packets packed eight bytes
// to a word, earliest byte lowest; the pair flagged last_pair flushes everything and
// ends with a zero byte on a word marked end_of_line. One pair is handled at a time:
// a pair that extends the current run or literal passes through the tail check; starting
// a new block adds the pass step, a literal moved into the held stage is copied pair by
// pair through the memory port, and held bytes are sent one by one, held up by any
// output stall. Both literal stores need no clearing after reset.
`default_nettype none
module pair_run_length_encoder (
  input  wire         clk,
  input  wire         rst_n,
  prle_in_if.sink     in_req,
  prle_out_if.source  out_rsp
);
  prle_pkg::byte_req_t emit;
  logic                byte_ok;

  prle_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .emit    (emit),
    .byte_ok (byte_ok)
  );

  prle_packer u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .emit    (emit),
    .byte_ok (byte_ok),
    .out_rsp (out_rsp)
  );
endmodule
`default_nettype wire

>>> rtl/prle_packer.sv
// packs emitted bytes eight to a word and holds the result word register
// depends on prle_pkg, prle_out_if and the macros header
`default_nettype none
`include "pair_run_length_encoder_macros.svh"
module prle_packer (
  input  wire                 clk,
  input  wire                 rst_n,
  input  prle_pkg::byte_req_t emit,
  output logic                byte_ok,
  prle_out_if.source          out_rsp
);
  logic [63:0] word_r, word_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] ow_r, ow_nxt;
  logic [3:0]  oc_r, oc_nxt;
  logic        oe_r, oe_nxt;
  logic        fin, out_free, push;
  logic [63:0] merged;

  assign fin      = (fill_r == 3'd7) || emit.term;
  assign out_free = !ov_r || out_rsp.ready;
  assign byte_ok  = !fin || out_free;
  assign push     = emit.valid && byte_ok;
  assign merged   = word_r | ({56'd0, emit.data} << {fill_r, 3'b000});

  always_comb begin
    word_nxt = word_r;
    fill_nxt = fill_r;
    ov_nxt   = ov_r && !out_rsp.ready;
    ow_nxt   = ow_r;
    oc_nxt   = oc_r;
    oe_nxt   = oe_r;
    if (push) begin
      if (fin) begin
        ov_nxt   = 1'b1;
        ow_nxt   = merged;
        oc_nxt   = {1'b0, fill_r} + 4'd1;
        oe_nxt   = emit.term;
        word_nxt = '0;
        fill_nxt = '0;
      end else begin
        word_nxt = merged;
        fill_nxt = fill_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      fill_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      word_r <= word_nxt;
      fill_r <= fill_nxt;
      ov_r   <= ov_nxt;
    end
    ow_r <= ow_nxt;
    oc_r <= oc_nxt;
    oe_r <= oe_nxt;
  end

  assign out_rsp.valid        = ov_r;
  assign out_rsp.packed_bytes = ow_r;
  assign out_rsp.byte_count   = oc_r;
  assign out_rsp.end_of_line  = oe_r;

  `PRLE_ASSERT_NOW(a_count_range, ov_r, (oc_r != 4'd0) && (oc_r <= 4'd8), "bad byte count")
  `PRLE_ASSERT_NOW(a_full_unless_eol, ov_r && !oe_r, oc_r == 4'd8, "short word before line end")
  `PRLE_ASSERT_NEXT(a_word_restarts, push && fin, (fill_r == 3'd0) && (word_r == 64'd0), "packer not cleared")
endmodule
`default_nettype wire

>>> rtl/prle_ctrl.sv
// sequencer with the run/literal merge stage, held literal stage and both pair memories
// depends on prle_pkg and prle_in_if
`default_nettype none
module prle_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  prle_in_if.sink              in_req,
  output prle_pkg::byte_req_t  emit,
  input  wire                  byte_ok
);
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_PASS   = 14'b00000000000010,
    S_RUN_H  = 14'b00000000000100,
    S_RUN_V  = 14'b00000000001000,
    S_CP_RD  = 14'b00000000010000,
    S_CP_WR  = 14'b00000000100000,
    S_PDONE  = 14'b00000001000000,
    S_TAIL   = 14'b00000010000000,
    S_SH_HDR = 14'b00000100000000,
    S_SH_RD  = 14'b00001000000000,
    S_SH_B0  = 14'b00010000000000,
    S_SH_B1  = 14'b00100000000000,
    S_TERM   = 14'b01000000000000,
    S_SPARE  = 14'b10000000000000
  } state_t;

  localparam int LenW = prle_pkg::LenW;
  localparam int Aw   = prle_pkg::PairAw;
  localparam logic [LenW:0] LitLim = (LenW+1)'(prle_pkg::MaxLitBytes);
  localparam logic [LenW:0] RunLim = (LenW+1)'(prle_pkg::MaxRunBytes);
  localparam logic [LenW-1:0] Two  = LenW'(2);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [7:0] a_r, b_r;
  logic       last_r, phase_last_r, phase_last_nxt;
  prle_pkg::kind_t mkind_r, mkind_nxt, hkind_r, hkind_nxt;
  logic [7:0]      mval_r, mval_nxt;
  logic [LenW-1:0] mlen_r, mlen_nxt, hlen_r, hlen_nxt;
  logic [Aw-1:0]   idx_r, idx_nxt, idx_inc;

  logic [15:0] merge_mem [prle_pkg::MemDepth];
  logic [15:0] held_mem  [prle_pkg::MemDepth];
  logic          m_we, m_re, h_we, h_re;
  logic [Aw-1:0] m_wa, m_ra, h_wa, h_ra;
  logic [15:0]   m_wd, h_wd, m_rd_r, h_rd_r;

  logic accept, is_run, ext_run, ext_lit, held_lit, settle_send;
  logic [LenW:0] sum_hm, sum_h2, sum_m2, next_min;

  assign accept   = in_req.valid && in_req.ready;
  assign is_run   = in_req.first_byte == in_req.second_byte;
  assign sum_m2   = {1'b0, mlen_r} + {1'b0, Two};
  assign sum_h2   = {1'b0, hlen_r} + {1'b0, Two};
  assign sum_hm   = {1'b0, hlen_r} + {1'b0, mlen_r};
  assign ext_run  = (mkind_r == prle_pkg::KIND_RUN) && is_run &&
                    (mval_r == in_req.first_byte) && (sum_m2 <= RunLim);
  assign ext_lit  = (mkind_r == prle_pkg::KIND_LIT) && !is_run && (sum_m2 <= LitLim);
  assign held_lit = hkind_r == prle_pkg::KIND_LIT;
  assign next_min = (mkind_r == prle_pkg::KIND_LIT) ? {1'b0, mlen_r} : {1'b0, Two};
  assign settle_send = held_lit &&
                       (((mkind_r == prle_pkg::KIND_RUN) && (mlen_r > Two)) ||
                        (({1'b0, hlen_r} + next_min) > LitLim));
  assign idx_inc  = idx_r + Aw'(1);
  assign in_req.ready = state_r == S_IDLE;

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    phase_last_nxt = phase_last_r;
    mkind_nxt      = mkind_r;
    mval_nxt       = mval_r;
    mlen_nxt       = mlen_r;
    hkind_nxt      = hkind_r;
    hlen_nxt       = hlen_r;
    idx_nxt        = idx_r;
    m_we = 1'b0; m_wa = mlen_r[LenW-1:1]; m_wd = {b_r, a_r};
    m_re = 1'b0; m_ra = idx_r;
    h_we = 1'b0; h_wa = hlen_r[LenW-1:1]; h_wd = {mval_r, mval_r};
    h_re = 1'b0; h_ra = idx_r;
    emit = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (ext_run) begin
            mlen_nxt  = sum_m2[LenW-1:0];
            state_nxt = S_TAIL;
          end else if (ext_lit) begin
            m_we      = 1'b1;
            m_wd      = {in_req.second_byte, in_req.first_byte};
            mlen_nxt  = sum_m2[LenW-1:0];
            state_nxt = S_TAIL;
          end else begin
            phase_last_nxt = 1'b0;
            state_nxt      = S_PASS;
          end
        end
      end
      S_PASS: begin
        idx_nxt = '0;
        unique case (mkind_r)
          prle_pkg::KIND_RUN: begin
            if (held_lit && (mlen_r == Two) && (sum_h2 <= LitLim)) begin
              h_we      = 1'b1;
              hlen_nxt  = sum_h2[LenW-1:0];
              state_nxt = S_PDONE;
            end else if (held_lit) begin
              ret_nxt   = S_RUN_H;
              state_nxt = S_SH_HDR;
            end else begin
              state_nxt = S_RUN_H;
            end
          end
          prle_pkg::KIND_LIT: begin
            if (held_lit && (sum_hm <= LitLim)) begin
              state_nxt = S_CP_RD;
            end else if (held_lit) begin
              ret_nxt   = S_CP_RD;
              state_nxt = S_SH_HDR;
            end else begin
              state_nxt = S_CP_RD;
            end
          end
          default: state_nxt = S_PDONE;
        endcase
      end
      S_RUN_H: begin
        emit = '{valid: 1'b1, data: prle_pkg::RunFlag | 8'(mlen_r[LenW-1:1]), term: 1'b0};
        if (byte_ok) state_nxt = S_RUN_V;
      end
      S_RUN_V: begin
        emit = '{valid: 1'b1, data: mval_r, term: 1'b0};
        if (byte_ok) state_nxt = S_PDONE;
      end
      S_CP_RD: begin
        m_re      = 1'b1;
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        h_we = 1'b1;
        h_wa = hlen_r[LenW-1:1] + idx_r;
        h_wd = m_rd_r;
        if (idx_inc == mlen_r[LenW-1:1]) begin
          hkind_nxt = prle_pkg::KIND_LIT;
          hlen_nxt  = sum_hm[LenW-1:0];
          state_nxt = S_PDONE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_CP_RD;
        end
      end
      S_PDONE: begin
        mkind_nxt = prle_pkg::KIND_NONE;
        mlen_nxt  = '0;
        mval_nxt  = '0;
        if (!phase_last_r) begin
          mlen_nxt = Two;
          if (a_r == b_r) begin
            mkind_nxt = prle_pkg::KIND_RUN;
            mval_nxt  = a_r;
          end else begin
            mkind_nxt = prle_pkg::KIND_LIT;
            m_we      = 1'b1;
            m_wa      = '0;
          end
          state_nxt = S_TAIL;
        end else if (held_lit) begin
          ret_nxt   = S_TERM;
          state_nxt = S_SH_HDR;
        end else begin
          state_nxt = S_TERM;
        end
      end
      S_TAIL: begin
        if (last_r) begin
          phase_last_nxt = 1'b1;
          state_nxt      = S_PASS;
        end else if (settle_send) begin
          ret_nxt   = S_IDLE;
          state_nxt = S_SH_HDR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SH_HDR: begin
        emit = '{valid: 1'b1, data: 8'(hlen_r[LenW-1:1]), term: 1'b0};
        if (byte_ok) begin
          idx_nxt   = '0;
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        h_re      = 1'b1;
        state_nxt = S_SH_B0;
      end
      S_SH_B0: begin
        emit = '{valid: 1'b1, data: h_rd_r[7:0], term: 1'b0};
        if (byte_ok) state_nxt = S_SH_B1;
      end
      S_SH_B1: begin
        emit = '{valid: 1'b1, data: h_rd_r[15:8], term: 1'b0};
        if (byte_ok) begin
          if (idx_inc == hlen_r[LenW-1:1]) begin
            hkind_nxt = prle_pkg::KIND_NONE;
            hlen_nxt  = '0;
            idx_nxt   = '0;
            state_nxt = ret_r;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_SH_RD;
          end
        end
      end
      S_TERM: begin
        emit = '{valid: 1'b1, data: 8'd0, term: 1'b1};
        if (byte_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      phase_last_r <= 1'b0;
      mkind_r      <= prle_pkg::KIND_NONE;
      mval_r       <= '0;
      mlen_r       <= '0;
      hkind_r      <= prle_pkg::KIND_NONE;
      hlen_r       <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      phase_last_r <= phase_last_nxt;
      mkind_r      <= mkind_nxt;
      mval_r       <= mval_nxt;
      mlen_r       <= mlen_nxt;
      hkind_r      <= hkind_nxt;
      hlen_r       <= hlen_nxt;
      idx_r        <= idx_nxt;
    end
    if (accept) begin
      a_r    <= in_req.first_byte;
      b_r    <= in_req.second_byte;
      last_r <= in_req.last_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) merge_mem[m_wa] <= m_wd;
    if (m_re) m_rd_r <= merge_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we) held_mem[h_wa] <= h_wd;
    if (h_re) h_rd_r <= held_mem[h_ra];
  end
endmodule
`default_nettype wire

>>> test/tb.sv
// testbench for pair_run_length_encoder: sends lines of byte pairs and checks packed packet words
// depends on prle_pkg and prle_if; has its own encoder predictor and compares every result word
`default_nettype none
module tb;
  typedef struct {
    logic [63:0] word;
    logic [3:0]  fill;
    logic        eol;
  } packed_word_t;

  typedef struct {
    logic [7:0] a;
    logic [7:0] b;
  } byte_pair_t;

  localparam int WatchLimit = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  prle_in_if  in_ch ();
  prle_out_if out_ch ();

  pair_run_length_encoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch.sink),
    .out_rsp(out_ch.source)
  );

  // encoder state mirror
  prle_pkg::kind_t m_kind, h_kind;
  logic [7:0]  m_value;
  int          m_len, h_len;
  logic [7:0]  m_store [prle_pkg::MaxLitBytes];
  logic [7:0]  h_store [prle_pkg::MaxLitBytes];
  logic [63:0] pk_word;
  int          pk_fill;

  packed_word_t expected_words [$];
  int errors = 0;
  int words_seen = 0;
  int pairs_sent = 0;
  int lines_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;

  task automatic flush_word(input logic eol);
    packed_word_t w;
    w.word = pk_word;
    w.fill = pk_fill[3:0];
    w.eol  = eol;
    expected_words.push_back(w);
    pk_word = '0;
    pk_fill = 0;
  endtask

  task automatic pack_byte(input logic [7:0] b);
    pk_word |= {56'd0, b} << (8 * pk_fill);
    pk_fill++;
    if (pk_fill >= 8) flush_word(1'b0);
  endtask

  task automatic emit_held_literal();
    if (h_kind != prle_pkg::KIND_LIT) return;
    pack_byte(8'(h_len / 2));
    for (int i = 0; i < h_len; i++) pack_byte(h_store[i]);
    h_kind = prle_pkg::KIND_NONE;
    h_len  = 0;
  endtask

  task automatic move_block_to_held();
    if (m_kind == prle_pkg::KIND_RUN) begin
      if (h_kind == prle_pkg::KIND_LIT && m_len == 2 &&
          h_len + 2 <= prle_pkg::MaxLitBytes) begin
        h_store[h_len]     = m_value;
        h_store[h_len + 1] = m_value;
        h_len += 2;
      end else begin
        emit_held_literal();
        pack_byte(8'(m_len / 2) + prle_pkg::RunFlag);
        pack_byte(m_value);
      end
    end else if (m_kind == prle_pkg::KIND_LIT) begin
      if (h_kind == prle_pkg::KIND_LIT && h_len + m_len <= prle_pkg::MaxLitBytes) begin
        for (int i = 0; i < m_len; i++) h_store[h_len + i] = m_store[i];
        h_len += m_len;
      end else begin
        emit_held_literal();
        for (int i = 0; i < m_len; i++) h_store[i] = m_store[i];
        h_kind = prle_pkg::KIND_LIT;
        h_len  = m_len;
      end
    end
    m_kind  = prle_pkg::KIND_NONE;
    m_len   = 0;
    m_value = '0;
  endtask

  task automatic encode_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
    bit equal;
    int next_min;
    equal = (a == b);
    if (m_kind == prle_pkg::KIND_RUN && equal && m_value == a &&
        m_len + 2 <= prle_pkg::MaxRunBytes) begin
      m_len += 2;
    end else if (m_kind == prle_pkg::KIND_LIT && !equal &&
                 m_len + 2 <= prle_pkg::MaxLitBytes) begin
      m_store[m_len]     = a;
      m_store[m_len + 1] = b;
      m_len += 2;
    end else begin
      move_block_to_held();
      m_len = 2;
      if (equal) begin
        m_kind  = prle_pkg::KIND_RUN;
        m_value = a;
      end else begin
        m_kind     = prle_pkg::KIND_LIT;
        m_value    = '0;
        m_store[0] = a;
        m_store[1] = b;
      end
    end
    if (last) begin
      move_block_to_held();
      emit_held_literal();
      pack_byte(8'h00);
      if (pk_fill > 0) flush_word(1'b1);
      else expected_words[$].eol = 1'b1;
    end else if (h_kind == prle_pkg::KIND_LIT) begin
      if (m_kind == prle_pkg::KIND_RUN && m_len > 2) begin
        emit_held_literal();
      end else begin
        next_min = (m_kind == prle_pkg::KIND_LIT) ? m_len : 2;
        if (h_len + next_min > prle_pkg::MaxLitBytes) emit_held_literal();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    packed_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_ch.packed_bytes, 64'd0);
      end else begin
        w = expected_words.pop_front();
        if (out_ch.packed_bytes !== w.word) report_mismatch("packed_bytes", out_ch.packed_bytes, w.word);
        if (out_ch.byte_count !== w.fill) report_mismatch("byte_count", out_ch.byte_count, w.fill);
        if (out_ch.end_of_line !== w.eol) report_mismatch("end_of_line", out_ch.end_of_line, w.eol);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no request moving either way
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.first_byte  = a;
    in_ch.second_byte = b;
    in_ch.last_pair   = last;
    do @(posedge clk); while (!in_ch.ready);
    encode_pair(a, b, last);
    pairs_sent++;
    if (last) lines_sent++;
  endtask

  task automatic send_line(input byte_pair_t line [$]);
    foreach (line[i]) send_pair(line[i].a, line[i].b, i == line.size() - 1);
  endtask

  task automatic add_run(inout byte_pair_t line [$], input logic [7:0] v, input int pairs);
    for (int i = 0; i < pairs; i++) line.push_back('{v, v});
  endtask

  task automatic add_literal(inout byte_pair_t line [$], input int pairs);
    logic [7:0] a;
    for (int i = 0; i < pairs; i++) begin
      a = 8'($urandom);
      line.push_back('{a, a ^ 8'($urandom_range(255, 1))});
    end
  endtask

  task automatic test_directed();
    byte_pair_t line [$];
    send_pair(8'h00, 8'h00, 1'b1);
    send_pair(8'hff, 8'h00, 1'b1);
    send_pair(8'h00, 8'hff, 1'b1);
    send_pair(8'hff, 8'hff, 1'b1);
    // literal then two-byte run absorbed, then literal merged
    line = {};
    add_literal(line, 2);
    add_run(line, 8'h55, 1);
    add_literal(line, 1);
    send_line(line);
    // literal released early by a longer run
    line = {};
    add_literal(line, 1);
    add_run(line, 8'haa, 3);
    add_literal(line, 1);
    add_run(line, 8'h00, 1);
    send_line(line);
    // runs of different values side by side
    line = {};
    add_run(line, 8'h01, 2);
    add_run(line, 8'h80, 1);
    add_run(line, 8'h7f, 1);
    send_line(line);
  endtask

  task automatic test_block_limits();
    byte_pair_t line [$];
    // literal splits past its limit, the full held literal is released at once
    line = {};
    add_run(line, 8'hc3, 2);
    add_literal(line, 127);
    send_line(line);
  endtask

  task automatic test_random_lines(input int pair_budget);
    byte_pair_t line [$];
    int start;
    start = pairs_sent;
    while (pairs_sent - start < pair_budget) begin
      line = {};
      repeat ($urandom_range(5, 1)) begin
        case ($urandom_range(5))
          0, 1: add_run(line, 8'($urandom), $urandom_range(3, 1));
          2: add_run(line, 8'($urandom), $urandom_range(12, 1));
          3, 4: add_literal(line, $urandom_range(6, 1));
          default: line.push_back('{8'($urandom), 8'($urandom)});
        endcase
      end
      send_line(line);
    end
  endtask

  task automatic set_idling(input int src_pct, input int dst_pct);
    idle_pct  = src_pct;
    stall_pct = dst_pct;
  endtask

  initial begin
    int waited;
    in_ch.valid       = 1'b0;
    in_ch.first_byte  = '0;
    in_ch.second_byte = '0;
    in_ch.last_pair   = 1'b0;
    m_kind = prle_pkg::KIND_NONE; h_kind = prle_pkg::KIND_NONE;
    m_value = '0; m_len = 0; h_len = 0;
    pk_word = '0; pk_fill = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_idling(0, 0);
    test_directed();
    test_random_lines(6);
    set_idling(45, 0);
    test_random_lines(6);
    test_block_limits();
    set_idling(0, 45);
    test_random_lines(6);
    set_idling(6, 6);
    test_random_lines(6);

    @(negedge clk);
    in_ch.valid = 1'b0;
    waited = 0;
    while (expected_words.size() != 0 && waited < WatchLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);

    $display("sent %0d pairs in %0d lines, checked %0d packed words", pairs_sent,
             lines_sent, words_seen);
    $display("covered runs, literals, merging across limits and four idling mixes");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d words missing", errors, expected_words.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/prle_pkg.sv
rtl/prle_if.sv
rtl/prle_packer.sv
rtl/prle_ctrl.sv
rtl/pair_run_length_encoder.sv
test/tb.sv
